@@ rtl/core/adcf_pkg.sv @@
// Shared constants, types and codes for the ADC distance ASCII framer.
package adcf_pkg;

	// sample and arithmetic widths
	localparam int SAMPLE_BITS = 10;
	localparam int FS_W        = 16;
	localparam int PROD_W      = SAMPLE_BITS + FS_W;
	localparam int CNT_W       = $clog2(PROD_W);
	localparam int DIGITS      = 4;
	localparam int BCD_W       = 4 * DIGITS;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_FULL_SCALE = 1'b0;   // register index, paddr[2]

	// reset values
	localparam logic [SAMPLE_BITS-1:0] TOP_RESET    = SAMPLE_BITS'(1022);
	localparam logic [SAMPLE_BITS-1:0] BOTTOM_RESET = SAMPLE_BITS'(88);
	localparam logic [FS_W-1:0]        FS_RESET     = FS_W'(1000);

	// largest value shown without overflow
	localparam logic [PROD_W-1:0] MAX_SHOWN = PROD_W'(9999);

	// frame layout
	localparam int FRAME_LEN = 8;
	localparam int IDX_W     = $clog2(FRAME_LEN);
	localparam logic [IDX_W-1:0] IDX_STX   = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_D3    = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_POINT = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_D2    = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_D1    = IDX_W'(4);
	localparam logic [IDX_W-1:0] IDX_D0    = IDX_W'(5);
	localparam logic [IDX_W-1:0] IDX_SPACE = IDX_W'(6);
	localparam logic [IDX_W-1:0] IDX_ETX   = IDX_W'(7);

	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one converted reading, ready for framing
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic             overflow;
		logic             span_error;
	} frame_info_t;

	// front sequencer
	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_DIV  = 4'b0100,
		F_PUSH = 4'b1000
	} front_state_t;

endpackage

@@ rtl/core/adc_distance_ascii_framer_unit.sv @@
// Top level of the ADC distance ASCII framer: config register, front, queue and back.
//
//  channel   | direction | handshake            | beat
//  ----------+-----------+----------------------+----------------------------------------
//  sample in | in        | push / full          | sample, set_top_n, set_bottom_n
//  frame out | out       | pop / empty          | frame_byte, last_byte, overflow, span_error
//  config    | in        | psel/penable/pready  | full_scale at byte address 0
//
// Each sample passes through the front end in order: an accept step, a multiply step,
// one-bit restoring division (one step per product bit) and a queue write.
// A span error skips the division. The back end then sends the frame byte by byte.
// The two-entry queue lets the front convert the next sample while frames drain;
// full rises while the front is busy. Reset clears the queue, the output and the
// calibration points to 1022 (top) and 88 (bottom); full_scale resets to 1000.
module adc_distance_ascii_framer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// input queue side
	input  logic                                push,
	output logic                                full,
	input  logic [adcf_pkg::SAMPLE_BITS-1:0]    sample,
	input  logic                                set_top_n,
	input  logic                                set_bottom_n,
	// result queue side
	output logic                                empty,
	input  logic                                pop,
	output logic [7:0]                          frame_byte,
	output logic                                last_byte,
	output logic                                overflow,
	output logic                                span_error,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [adcf_pkg::APB_AW-1:0]         paddr,
	input  logic [adcf_pkg::APB_DW-1:0]         pwdata,
	output logic [adcf_pkg::APB_DW-1:0]         prdata,
	output logic                                pready
);

	logic [adcf_pkg::FS_W-1:0] full_scale_q;
	logic                      cfg_write;
	logic                      fs_sel;

	logic                  fq_push, fq_full, fq_pop, fq_avail;
	adcf_pkg::frame_info_t fq_wdata, fq_rdata;

	// configuration register
	assign pready    = 1'b1;
	assign fs_sel    = (paddr[2] == adcf_pkg::REG_FULL_SCALE);
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = fs_sel ? adcf_pkg::APB_DW'(full_scale_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= adcf_pkg::FS_RESET;
		end else if (cfg_write && fs_sel) begin
			full_scale_q <= pwdata[adcf_pkg::FS_W-1:0];
		end
	end

	adcf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.set_top_n    (set_top_n),
		.set_bottom_n (set_bottom_n),
		.full_scale   (full_scale_q),
		.q_push       (fq_push),
		.q_full       (fq_full),
		.q_data       (fq_wdata)
	);

	adcf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_wdata),
		.q_full  (fq_full),
		.rd_en   (fq_pop),
		.q_avail (fq_avail),
		.rd_data (fq_rdata)
	);

	adcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_avail    (fq_avail),
		.q_data     (fq_rdata),
		.q_pop      (fq_pop),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.overflow   (overflow),
		.span_error (span_error)
	);

endmodule

@@ rtl/core/adcf_front.sv @@
// Front end: accepts samples, latches calibration points, scales and converts to BCD.
module adcf_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [adcf_pkg::SAMPLE_BITS-1:0]    sample,
	input  logic                                set_top_n,
	input  logic                                set_bottom_n,
	input  logic [adcf_pkg::FS_W-1:0]           full_scale,
	output logic                                q_push,
	input  logic                                q_full,
	output adcf_pkg::frame_info_t               q_data
);

	localparam int SB = adcf_pkg::SAMPLE_BITS;
	localparam int PW = adcf_pkg::PROD_W;

	adcf_pkg::front_state_t state_q;
	logic [SB-1:0]                 top_q, bottom_q;
	logic [SB-1:0]                 sample_q;
	logic [SB-1:0]                 span_q;
	logic [SB-1:0]                 rem_q;
	logic [PW-1:0]                 work_q;
	logic [adcf_pkg::CNT_W-1:0]    cnt_q;
	logic [adcf_pkg::BCD_W-1:0]    bcd_q;
	logic                          serr_q;

	logic                 accept;
	logic                 span_bad;
	logic [SB-1:0]        diff;
	logic [PW-1:0]        product;
	logic [SB:0]          trial;
	logic [SB:0]          trial_sub;
	logic                 q_bit;
	logic [SB-1:0]        rem_next;
	logic [adcf_pkg::BCD_W-1:0] bcd_next;

	// add-3 correction then shift one quotient bit into the BCD digits
	function automatic logic [adcf_pkg::BCD_W-1:0] bcd_shift(
		input logic [adcf_pkg::BCD_W-1:0] v,
		input logic                       b
	);
		logic [adcf_pkg::BCD_W-1:0] a;
		a = v;
		for (int i = 0; i < adcf_pkg::DIGITS; i++) begin
			if (a[4*i +: 4] >= 4'd5) begin
				a[4*i +: 4] = a[4*i +: 4] + 4'd3;
			end
		end
		return {a[adcf_pkg::BCD_W-2:0], b};
	endfunction

	assign full   = (state_q != adcf_pkg::F_IDLE);
	assign accept = push && !full;

	// scale step
	assign span_bad = (top_q <= bottom_q);
	assign diff     = (sample_q > bottom_q) ? (sample_q - bottom_q) : '0;
	assign product  = PW'(diff) * PW'(full_scale);

	// one restoring division step per cycle
	assign trial     = {rem_q, work_q[PW-1]};
	assign trial_sub = trial - {1'b0, span_q};
	assign q_bit     = (trial >= {1'b0, span_q});
	assign rem_next  = q_bit ? trial_sub[SB-1:0] : trial[SB-1:0];
	assign bcd_next  = bcd_shift(bcd_q, q_bit);

	// handoff to the queue
	assign q_push            = (state_q == adcf_pkg::F_PUSH) && !q_full;
	assign q_data.bcd        = bcd_q;
	assign q_data.overflow   = (work_q > adcf_pkg::MAX_SHOWN);
	assign q_data.span_error = serr_q;

	// sequencer and calibration points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= adcf_pkg::F_IDLE;
			top_q    <= adcf_pkg::TOP_RESET;
			bottom_q <= adcf_pkg::BOTTOM_RESET;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				adcf_pkg::F_IDLE: begin
					if (accept) begin
						if (!set_top_n) top_q <= sample;
						if (!set_bottom_n) bottom_q <= sample;
						state_q <= adcf_pkg::F_MUL;
					end
				end
				adcf_pkg::F_MUL: begin
					cnt_q   <= '0;
					state_q <= span_bad ? adcf_pkg::F_PUSH : adcf_pkg::F_DIV;
				end
				adcf_pkg::F_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == adcf_pkg::CNT_W'(PW - 1)) begin
						state_q <= adcf_pkg::F_PUSH;
					end
				end
				adcf_pkg::F_PUSH: begin
					if (!q_full) state_q <= adcf_pkg::F_IDLE;
				end
				default: state_q <= adcf_pkg::F_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) sample_q <= sample;
		if (state_q == adcf_pkg::F_MUL) begin
			span_q <= top_q - bottom_q;
			rem_q  <= '0;
			bcd_q  <= '0;
			serr_q <= span_bad;
			work_q <= span_bad ? '0 : product;
		end else if (state_q == adcf_pkg::F_DIV) begin
			rem_q  <= rem_next;
			bcd_q  <= bcd_next;
			work_q <= {work_q[PW-2:0], q_bit};
		end
	end

endmodule

@@ rtl/core/adcf_queue.sv @@
// Short queue of converted readings between front and back.
module adcf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  adcf_pkg::frame_info_t wr_data,
	output logic                  q_full,
	input  logic                  rd_en,
	output logic                  q_avail,
	output adcf_pkg::frame_info_t rd_data
);

	adcf_pkg::frame_info_t             entries_q [adcf_pkg::QUEUE_DEPTH];
	logic [adcf_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [adcf_pkg::QCNT_W-1:0]       count_q;

	assign q_full  = (count_q == adcf_pkg::QCNT_W'(adcf_pkg::QUEUE_DEPTH));
	assign q_avail = (count_q != '0);
	assign rd_data = entries_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en) count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) entries_q[wr_ptr_q] <= wr_data;
	end

endmodule

@@ rtl/core/adcf_back.sv @@
// Back end: expands one converted reading into the 8-byte ASCII frame.
module adcf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_avail,
	input  adcf_pkg::frame_info_t q_data,
	output logic                  q_pop,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            frame_byte,
	output logic                  last_byte,
	output logic                  overflow,
	output logic                  span_error
);

	adcf_pkg::frame_info_t          cur_q;
	logic                           active_q;
	logic [adcf_pkg::IDX_W-1:0]     idx_q;
	logic                           out_valid_q;
	logic [7:0]                     byte_q;
	logic                           last_q, ovf_q, serr_q;

	logic       load;
	logic [7:0] next_byte;

	assign q_pop = !active_q && q_avail;
	assign load  = active_q && (!out_valid_q || pop);

	assign empty      = !out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;
	assign overflow   = ovf_q;
	assign span_error = serr_q;

	// byte of the frame at the current position
	always_comb begin
		unique case (idx_q)
			adcf_pkg::IDX_STX:   next_byte = adcf_pkg::CH_STX;
			adcf_pkg::IDX_D3:    next_byte = adcf_pkg::CH_ZERO | {4'd0, cur_q.bcd[15:12]};
			adcf_pkg::IDX_POINT: next_byte = adcf_pkg::CH_POINT;
			adcf_pkg::IDX_D2:    next_byte = adcf_pkg::CH_ZERO | {4'd0, cur_q.bcd[11:8]};
			adcf_pkg::IDX_D1:    next_byte = adcf_pkg::CH_ZERO | {4'd0, cur_q.bcd[7:4]};
			adcf_pkg::IDX_D0:    next_byte = adcf_pkg::CH_ZERO | {4'd0, cur_q.bcd[3:0]};
			adcf_pkg::IDX_SPACE: next_byte = adcf_pkg::CH_SPACE;
			adcf_pkg::IDX_ETX:   next_byte = adcf_pkg::CH_ETX;
			default:             next_byte = adcf_pkg::CH_ETX;
		endcase
	end

	// frame position and output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == adcf_pkg::IDX_ETX) active_q <= 1'b0;
			end
			if (load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
		if (load) begin
			byte_q <= next_byte;
			last_q <= (idx_q == adcf_pkg::IDX_ETX);
			ovf_q  <= cur_q.overflow;
			serr_q <= cur_q.span_error;
		end
	end

endmodule
